/* sv/pdss_pkg.sv */
`timescale 1ns / 1ps

package pdss_pkg;

  // number formats
  localparam int VEC_FRAC_BITS = 14;
  localparam int VEC_W         = VEC_FRAC_BITS + 2;
  localparam int COLOR_BITS    = 16;
  localparam int COL_FRAC      = COLOR_BITS - 2;
  localparam int EXP_BITS      = 8;

  // internal widths
  localparam int LN_W   = 19;                 // rounded l.n, signed
  localparam int DF_W   = LN_W - 1;           // clipped diffuse factor
  localparam int P_W    = LN_W + VEC_W;       // ln * n product
  localparam int R_W    = 22;                 // reflected component, signed
  localparam int RR_W   = 44;                 // squared length, unsigned
  localparam int LEN_W  = RR_W / 2;           // reflection length
  localparam int VD_W   = 41;                 // v.R, signed
  localparam int REM_W  = VD_W - 1;           // dividend magnitude
  localparam int COS_W  = VEC_FRAC_BITS + 1;  // cosine, 0 .. 1.0
  localparam int KI_W   = 18;                 // material times light
  localparam int SUM_W  = 24;                 // channel sum before clipping

  localparam logic [COS_W-1:0] VEC_ONE = COS_W'(1) << VEC_FRAC_BITS;

  typedef struct packed {
    logic [3*VEC_W-1:0]      normal_xyz;
    logic [3*VEC_W-1:0]      ray_dir_xyz;
    logic [3*VEC_W-1:0]      light_dir_xyz;
    logic [3*COLOR_BITS-1:0] diffuse_rgb;
    logic [3*COLOR_BITS-1:0] specular_rgb;
    logic [3*COLOR_BITS-1:0] light_rgb;
    logic [7:0]              shininess;
  } in_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] red_out;
    logic [COLOR_BITS-1:0] green_out;
    logic [COLOR_BITS-1:0] blue_out;
  } out_t;

  // per-item data that rides along the long specular path
  typedef struct packed {
    logic [2:0][KI_W-1:0] kdi;
    logic [2:0][KI_W-1:0] ksi;
    logic [DF_W-1:0]      diff;
    logic [EXP_BITS-1:0]  shin;
  } side_t;

endpackage

/* sv/pdss_isqrt.sv */
`timescale 1ns / 1ps

module pdss_isqrt #(
  parameter int IN_W   = 44,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic [IN_W-1:0]     in_x,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_vld,
  output logic [IN_W/2-1:0]   out_root,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int RT_W = IN_W / 2;
  localparam int TW   = IN_W + 2;

  logic              vld_r  [RT_W];
  logic [IN_W-1:0]   rem_r  [RT_W];
  logic [RT_W-1:0]   root_r [RT_W];
  logic [SIDE_W-1:0] side_r [RT_W];

  // one root bit per stage, most significant first
  for (genvar k = 0; k < RT_W; k++) begin : g_stage
    localparam int B = RT_W - 1 - k;
    logic              src_vld;
    logic [IN_W-1:0]   src_rem;
    logic [RT_W-1:0]   src_root;
    logic [SIDE_W-1:0] src_side;
    logic [TW-1:0]     trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign src_vld  = in_vld;
      assign src_rem  = in_x;
      assign src_root = '0;
      assign src_side = in_side;
    end else begin : g_next
      assign src_vld  = vld_r[k-1];
      assign src_rem  = rem_r[k-1];
      assign src_root = root_r[k-1];
      assign src_side = side_r[k-1];
    end

    // (q + 2^b)^2 - q^2 = q*2^(b+1) + 2^(2b)
    assign trial = (TW'(src_root) << (B + 1)) | (TW'(1) << (2 * B));
    assign ge    = TW'(src_rem) >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= ge ? (src_rem - trial[IN_W-1:0]) : src_rem;
      root_r[k] <= ge ? (src_root | (RT_W'(1) << B)) : src_root;
      side_r[k] <= src_side;
    end
  end

  assign out_vld  = vld_r[RT_W-1];
  assign out_root = root_r[RT_W-1];
  assign out_side = side_r[RT_W-1];

endmodule

/* sv/pdss_pow.sv */
`timescale 1ns / 1ps

module pdss_pow #(
  parameter int SIDE_W = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [pdss_pkg::COS_W-1:0]    in_base,
  input  logic [pdss_pkg::EXP_BITS-1:0] in_expo,
  input  logic [SIDE_W-1:0]             in_side,
  output logic                          out_vld,
  output logic [pdss_pkg::COS_W-1:0]    out_pow,
  output logic [SIDE_W-1:0]             out_side
);
  import pdss_pkg::*;

  localparam int NST  = 2 * EXP_BITS;
  localparam int PR_W = 2 * COS_W + 1;

  logic                vld_r  [NST];
  logic [COS_W-1:0]    acc_r  [NST];
  logic [COS_W-1:0]    base_r [NST];
  logic [EXP_BITS-1:0] expo_r [NST];
  logic [SIDE_W-1:0]   side_r [NST];

  // square on even stages, multiply by base on odd stages when the bit is set
  for (genvar s = 0; s < NST; s++) begin : g_stage
    localparam int B = EXP_BITS - 1 - s / 2;
    logic                src_vld;
    logic [COS_W-1:0]    src_acc;
    logic [COS_W-1:0]    src_base;
    logic [EXP_BITS-1:0] src_expo;
    logic [SIDE_W-1:0]   src_side;
    logic [COS_W-1:0]    mul_b;
    logic                use_mul;
    logic [PR_W-1:0]     prod;
    logic [COS_W-1:0]    acc_nxt;

    if (s == 0) begin : g_first
      assign src_vld  = in_vld;
      assign src_acc  = VEC_ONE;
      assign src_base = in_base;
      assign src_expo = in_expo;
      assign src_side = in_side;
    end else begin : g_next
      assign src_vld  = vld_r[s-1];
      assign src_acc  = acc_r[s-1];
      assign src_base = base_r[s-1];
      assign src_expo = expo_r[s-1];
      assign src_side = side_r[s-1];
    end

    if (s % 2 == 0) begin : g_sq
      assign mul_b   = src_acc;
      assign use_mul = 1'b1;
    end else begin : g_mul
      assign mul_b   = src_base;
      assign use_mul = src_expo[B];
    end

    // rounded half up back to the vector fraction
    assign prod    = PR_W'(src_acc) * PR_W'(mul_b) + (PR_W'(1) << (VEC_FRAC_BITS - 1));
    assign acc_nxt = use_mul ? prod[VEC_FRAC_BITS +: COS_W] : src_acc;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      acc_r[s]  <= acc_nxt;
      base_r[s] <= src_base;
      expo_r[s] <= src_expo;
      side_r[s] <= src_side;
    end
  end

  assign out_vld  = vld_r[NST-1];
  assign out_pow  = acc_r[NST-1];
  assign out_side = side_r[NST-1];

endmodule

/* sv/phong_diffuse_specular_shader_core.sv */
`timescale 1ns / 1ps
// Phong diffuse plus specular shader, fully pipelined.
// Pipeline: 6 front stages, 22 square-root stages, 1 divide entry, 15 divide stages,
// 1 clamp, 16 power stages, 1 color stage and the output register.
// Throughput: one item per cycle; busy stays low, the receiver cannot stall.
// Reset: synchronous active-low rst_n clears every stage valid bit; data registers are not reset.

module phong_diffuse_specular_shader_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  pdss_pkg::in_t   in_data,
  output logic            out_valid,
  output pdss_pkg::out_t  out_data
);
  import pdss_pkg::*;

  localparam int SQS_W = VD_W + $bits(side_t);
  localparam int QB    = COS_W;           // quotient bits before clamping
  localparam int KP_W  = 2 * COLOR_BITS + 1;

  assign busy = 1'b0;

  // stage 1: unpack, l*n products, material times light products
  logic                          v1_r;
  logic signed [VEC_W-1:0]       n1_r  [3];
  logic signed [VEC_W-1:0]       l1_r  [3];
  logic signed [VEC_W:0]         w1_r  [3];
  logic signed [2*VEC_W-1:0]     ln1_r [3];
  logic [2*COLOR_BITS-1:0]       kd1_r [3];
  logic [2*COLOR_BITS-1:0]       ks1_r [3];
  logic [EXP_BITS-1:0]           shin1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      logic signed [VEC_W-1:0] nc;
      logic signed [VEC_W-1:0] lc;
      logic signed [VEC_W-1:0] rc;
      logic [COLOR_BITS-1:0]   li;
      nc = $signed(in_data.normal_xyz[i*VEC_W +: VEC_W]);
      lc = $signed(in_data.light_dir_xyz[i*VEC_W +: VEC_W]);
      rc = $signed(in_data.ray_dir_xyz[i*VEC_W +: VEC_W]);
      li = in_data.light_rgb[i*COLOR_BITS +: COLOR_BITS];
      n1_r[i]  <= nc;
      l1_r[i]  <= lc;
      w1_r[i]  <= -((VEC_W+1)'(rc));
      ln1_r[i] <= nc * lc;
      kd1_r[i] <= in_data.diffuse_rgb[i*COLOR_BITS +: COLOR_BITS] * li;
      ks1_r[i] <= in_data.specular_rgb[i*COLOR_BITS +: COLOR_BITS] * li;
    end
    shin1_r <= in_data.shininess[EXP_BITS-1:0];
  end

  // stage 2: rounded l.n and rounded color products
  logic                      v2_r;
  logic signed [LN_W-1:0]    ln2_r;
  logic signed [VEC_W-1:0]   n2_r [3];
  logic signed [VEC_W-1:0]   l2_r [3];
  logic signed [VEC_W:0]     w2_r [3];
  logic [2:0][KI_W-1:0]      kdi2_r;
  logic [2:0][KI_W-1:0]      ksi2_r;
  logic [EXP_BITS-1:0]       shin2_r;

  logic signed [2*VEC_W+1:0] dot_c;
  logic signed [2*VEC_W+1:0] dot_rnd;
  assign dot_c   = (2*VEC_W+2)'(ln1_r[0]) + (2*VEC_W+2)'(ln1_r[1]) + (2*VEC_W+2)'(ln1_r[2])
                 + ((2*VEC_W+2)'(1) <<< (VEC_FRAC_BITS - 1));
  assign dot_rnd = dot_c >>> VEC_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      logic [KP_W-1:0] kd_t;
      logic [KP_W-1:0] ks_t;
      kd_t = KP_W'(kd1_r[i]) + (KP_W'(1) << (COL_FRAC - 1));
      ks_t = KP_W'(ks1_r[i]) + (KP_W'(1) << (COL_FRAC - 1));
      kdi2_r[i] <= kd_t[COL_FRAC +: KI_W];
      ksi2_r[i] <= ks_t[COL_FRAC +: KI_W];
      n2_r[i]   <= n1_r[i];
      l2_r[i]   <= l1_r[i];
      w2_r[i]   <= w1_r[i];
    end
    ln2_r   <= dot_rnd[LN_W-1:0];
    shin2_r <= shin1_r;
  end

  // stage 3: ln * n products, diffuse factor clipped at zero
  logic                    v3_r;
  logic signed [P_W-1:0]   p3_r [3];
  logic signed [VEC_W-1:0] l3_r [3];
  logic signed [VEC_W:0]   w3_r [3];
  side_t                   side3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      p3_r[i] <= ln2_r * n2_r[i];
      l3_r[i] <= l2_r[i];
      w3_r[i] <= w2_r[i];
    end
    side3_r.kdi  <= kdi2_r;
    side3_r.ksi  <= ksi2_r;
    side3_r.diff <= (ln2_r > 0) ? ln2_r[DF_W-1:0] : '0;
    side3_r.shin <= shin2_r;
  end

  // stage 4: reflected vector R = round(2 ln n) - l
  logic                  v4_r;
  logic signed [R_W-1:0] r4_r [3];
  logic signed [VEC_W:0] w4_r [3];
  side_t                 side4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      logic signed [P_W+1:0] t2;
      logic signed [P_W+1:0] t2s;
      t2  = $signed({p3_r[i][P_W-1], p3_r[i], 1'b0}) + ((P_W+2)'(1) <<< (VEC_FRAC_BITS - 1));
      t2s = t2 >>> VEC_FRAC_BITS;
      r4_r[i] <= t2s[R_W-1:0] - R_W'(l3_r[i]);
      w4_r[i] <= w3_r[i];
    end
    side4_r <= side3_r;
  end

  // stage 5: R squared and v times R
  logic                           v5_r;
  logic signed [2*R_W-1:0]        sq5_r [3];
  logic signed [R_W+VEC_W:0]      vr5_r [3];
  side_t                          side5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq5_r[i] <= r4_r[i] * r4_r[i];
      vr5_r[i] <= (R_W+VEC_W+1)'(r4_r[i]) * (R_W+VEC_W+1)'(w4_r[i]);
    end
    side5_r <= side4_r;
  end

  // stage 6: sums for |R|^2 and v.R
  logic                   v6_r;
  logic [RR_W-1:0]        rr6_r;
  logic signed [VD_W-1:0] vd6_r;
  side_t                  side6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    rr6_r   <= RR_W'(unsigned'(sq5_r[0])) + RR_W'(unsigned'(sq5_r[1]))
             + RR_W'(unsigned'(sq5_r[2]));
    vd6_r   <= VD_W'(vr5_r[0]) + VD_W'(vr5_r[1]) + VD_W'(vr5_r[2]);
    side6_r <= side5_r;
  end

  // square root of |R|^2, one root bit per stage
  logic             sq_vld;
  logic [LEN_W-1:0] sq_len;
  logic [SQS_W-1:0] sq_side;

  pdss_isqrt #(
    .IN_W   (RR_W),
    .SIDE_W (SQS_W)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v6_r),
    .in_x     (rr6_r),
    .in_side  ({vd6_r, side6_r}),
    .out_vld  (sq_vld),
    .out_root (sq_len),
    .out_side (sq_side)
  );

  logic signed [VD_W-1:0] sq_vd;
  side_t                  sq_sd;
  assign sq_vd = $signed(sq_side[SQS_W-1 -: VD_W]);
  assign sq_sd = sq_side[$bits(side_t)-1:0];

  // divide entry: zero and overflow checks
  logic             d0_vld_r;
  logic [REM_W-1:0] d0_rem_r;
  logic [LEN_W-1:0] d0_len_r;
  logic             d0_zero_r;
  logic             d0_sat_r;
  side_t            d0_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d0_vld_r <= 1'b0;
    end else begin
      d0_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    d0_rem_r  <= sq_vd[REM_W-1:0];
    d0_len_r  <= sq_len;
    d0_zero_r <= (sq_vd <= 0) || (sq_len == '0);
    d0_sat_r  <= sq_vd[REM_W-1:0] >= (REM_W'(sq_len) << QB);
    d0_side_r <= sq_sd;
  end

  // restoring divide, one quotient bit per stage
  logic             dq_vld_r  [QB];
  logic [REM_W-1:0] dq_rem_r  [QB];
  logic [QB-1:0]    dq_q_r    [QB];
  logic [LEN_W-1:0] dq_len_r  [QB];
  logic             dq_zero_r [QB];
  logic             dq_sat_r  [QB];
  side_t            dq_side_r [QB];

  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int B = QB - 1 - k;
    logic             src_vld;
    logic [REM_W-1:0] src_rem;
    logic [QB-1:0]    src_q;
    logic [LEN_W-1:0] src_len;
    logic             src_zero;
    logic             src_sat;
    side_t            src_side;
    logic [REM_W-1:0] sub;
    logic             ge;

    if (k == 0) begin : g_first
      assign src_vld  = d0_vld_r;
      assign src_rem  = d0_rem_r;
      assign src_q    = '0;
      assign src_len  = d0_len_r;
      assign src_zero = d0_zero_r;
      assign src_sat  = d0_sat_r;
      assign src_side = d0_side_r;
    end else begin : g_next
      assign src_vld  = dq_vld_r[k-1];
      assign src_rem  = dq_rem_r[k-1];
      assign src_q    = dq_q_r[k-1];
      assign src_len  = dq_len_r[k-1];
      assign src_zero = dq_zero_r[k-1];
      assign src_sat  = dq_sat_r[k-1];
      assign src_side = dq_side_r[k-1];
    end

    assign sub = REM_W'(src_len) << B;
    assign ge  = src_rem >= sub;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dq_vld_r[k] <= 1'b0;
      end else begin
        dq_vld_r[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      dq_rem_r[k]  <= ge ? (src_rem - sub) : src_rem;
      dq_q_r[k]    <= ge ? (src_q | (QB'(1) << B)) : src_q;
      dq_len_r[k]  <= src_len;
      dq_zero_r[k] <= src_zero;
      dq_sat_r[k]  <= src_sat;
      dq_side_r[k] <= src_side;
    end
  end

  // cosine clamp to [0, 1.0]
  logic             c_vld_r;
  logic [COS_W-1:0] c_cos_r;
  side_t            c_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= dq_vld_r[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (dq_zero_r[QB-1]) begin
      c_cos_r <= '0;
    end else if (dq_sat_r[QB-1] || (dq_q_r[QB-1] > VEC_ONE)) begin
      c_cos_r <= VEC_ONE;
    end else begin
      c_cos_r <= dq_q_r[QB-1];
    end
    c_side_r <= dq_side_r[QB-1];
  end

  // cosine to the shininess power
  logic             pw_vld;
  logic [COS_W-1:0] pw_val;
  side_t            pw_side;

  pdss_pow #(
    .SIDE_W ($bits(side_t))
  ) u_pow (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (c_vld_r),
    .in_base  (c_cos_r),
    .in_expo  (c_side_r.shin),
    .in_side  (c_side_r),
    .out_vld  (pw_vld),
    .out_pow  (pw_val),
    .out_side (pw_side)
  );

  // color stage 1: scale by diffuse factor and specular power
  logic                     f1_vld_r;
  logic [KI_W+DF_W-1:0]     f1_pd_r [3];
  logic [KI_W+COS_W-1:0]    f1_ps_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else begin
      f1_vld_r <= pw_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      f1_pd_r[i] <= (KI_W+DF_W)'(pw_side.kdi[i]) * (KI_W+DF_W)'(pw_side.diff);
      f1_ps_r[i] <= (KI_W+COS_W)'(pw_side.ksi[i]) * (KI_W+COS_W)'(pw_val);
    end
  end

  // color stage 2: round, add and saturate
  logic [COLOR_BITS-1:0] ch_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [KI_W+DF_W:0]  td;
      logic [KI_W+COS_W:0] ts;
      logic [SUM_W-1:0]    t;
      td = (KI_W+DF_W+1)'(f1_pd_r[i]) + ((KI_W+DF_W+1)'(1) << (VEC_FRAC_BITS - 1));
      ts = (KI_W+COS_W+1)'(f1_ps_r[i]) + ((KI_W+COS_W+1)'(1) << (VEC_FRAC_BITS - 1));
      t  = SUM_W'(td >> VEC_FRAC_BITS) + SUM_W'(ts >> VEC_FRAC_BITS);
      ch_c[i] = (t > SUM_W'({COLOR_BITS{1'b1}})) ? {COLOR_BITS{1'b1}} : t[COLOR_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_data.red_out   <= ch_c[0];
    out_data.green_out <= ch_c[1];
    out_data.blue_out  <= ch_c[2];
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import pdss_pkg::*;

  localparam int LATENCY = 63;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_data = '0;
  logic out_valid;
  out_t out_data;

  out_t color_q[$];
  int n_fail = 0;
  int n_sent = 0;
  int n_seen = 0;
  int gap_pct = 0;

  always #10 clk = ~clk;

  phong_diffuse_specular_shader_core i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  function automatic longint vcomp(logic [3*VEC_W-1:0] w, int k);
    logic signed [VEC_W-1:0] c;
    c = w[k*VEC_W +: VEC_W];
    return longint'(c);
  endfunction

  // floor division by 2^s with rounding half up
  function automatic longint rnd_shr(longint x, int s);
    return (x + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint unsigned umul_rnd(longint unsigned a, longint unsigned b, int f);
    return (a * b + (longint'(1) << (f - 1))) >> f;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic out_t shade_color(in_t it);
    longint n[3], l[3], v[3], r[3];
    longint dot, ln, vd;
    longint unsigned rr, len, cosv, pw, diff, kdi, ksi, t, one;
    logic [EXP_BITS-1:0] m;
    logic [COLOR_BITS-1:0] ch[3];
    out_t o;
    dot = 0; vd = 0; rr = 0; cosv = 0;
    one = 64'd1 << VEC_FRAC_BITS;
    for (int i = 0; i < 3; i++) begin
      n[i] = vcomp(it.normal_xyz, i);
      v[i] = -vcomp(it.ray_dir_xyz, i);
      l[i] = vcomp(it.light_dir_xyz, i);
      dot += l[i] * n[i];
    end
    ln = rnd_shr(dot, VEC_FRAC_BITS);
    for (int i = 0; i < 3; i++) begin
      r[i] = rnd_shr(2 * ln * n[i], VEC_FRAC_BITS) - l[i];
      rr += longint'(r[i] * r[i]);
      vd += v[i] * r[i];
    end
    len = int_sqrt(rr);
    if (vd > 0 && len != 0) begin
      cosv = longint'(vd) / len;
      if (cosv > one) cosv = one;
    end
    // bounded square-and-multiply
    m = it.shininess[EXP_BITS-1:0];
    pw = one;
    for (int b = EXP_BITS - 1; b >= 0; b--) begin
      pw = umul_rnd(pw, pw, VEC_FRAC_BITS);
      if (m[b]) pw = umul_rnd(pw, cosv, VEC_FRAC_BITS);
    end
    diff = (ln > 0) ? ln : 0;
    for (int i = 0; i < 3; i++) begin
      kdi = umul_rnd(it.diffuse_rgb[i*COLOR_BITS +: COLOR_BITS],
                     it.light_rgb[i*COLOR_BITS +: COLOR_BITS], COL_FRAC);
      ksi = umul_rnd(it.specular_rgb[i*COLOR_BITS +: COLOR_BITS],
                     it.light_rgb[i*COLOR_BITS +: COLOR_BITS], COL_FRAC);
      t = umul_rnd(kdi, diff, VEC_FRAC_BITS) + umul_rnd(ksi, pw, VEC_FRAC_BITS);
      ch[i] = (t > 64'hFFFF) ? 16'hFFFF : t[COLOR_BITS-1:0];
    end
    o.red_out = ch[0];
    o.green_out = ch[1];
    o.blue_out = ch[2];
    return o;
  endfunction

  // send one hit point, with a random idle gap before it
  task automatic send_hit(in_t it);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    color_q.push_back(shade_color(it));
    n_sent++;
  endtask

  // compare each strobed color with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      out_t e;
      n_seen++;
      if (color_q.size() == 0) begin
        $error("color with no pending prediction: %h", out_data);
        n_fail++;
      end else begin
        e = color_q.pop_front();
        if (out_data.red_out !== e.red_out) begin
          $error("red_out expected %h actual %h", e.red_out, out_data.red_out);
          n_fail++;
        end
        if (out_data.green_out !== e.green_out) begin
          $error("green_out expected %h actual %h", e.green_out, out_data.green_out);
          n_fail++;
        end
        if (out_data.blue_out !== e.blue_out) begin
          $error("blue_out expected %h actual %h", e.blue_out, out_data.blue_out);
          n_fail++;
        end
      end
    end
  end

  function automatic logic [VEC_W-1:0] q14(int x);
    return x[VEC_W-1:0];
  endfunction

  function automatic logic [3*VEC_W-1:0] vec3(int x, int y, int z);
    return {q14(z), q14(y), q14(x)};
  endfunction

  // random vector: mostly uniform components in [-0.5, 0.5], sometimes raw random bits
  function automatic logic [3*VEC_W-1:0] rand_vec();
    int a[3];
    if ($urandom_range(9) < 2) return (3*VEC_W)'({$urandom, $urandom});
    for (int i = 0; i < 3; i++) a[i] = int'($urandom_range(32768)) - 16384;
    return vec3(a[0] / 2, a[1] / 2, a[2] / 2);
  endfunction

  function automatic logic [3*COLOR_BITS-1:0] rand_col();
    if ($urandom_range(3) == 0) return (3*COLOR_BITS)'({$urandom, $urandom});
    return {16'($urandom_range(16384)), 16'($urandom_range(16384)),
            16'($urandom_range(16384))};
  endfunction

  function automatic in_t rand_hit();
    in_t it;
    it.normal_xyz = rand_vec();
    it.ray_dir_xyz = rand_vec();
    it.light_dir_xyz = rand_vec();
    it.diffuse_rgb = rand_col();
    it.specular_rgb = rand_col();
    it.light_rgb = rand_col();
    it.shininess = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(16));
    return it;
  endfunction

  task automatic test_directed();
    in_t it;
    int one;
    one = 16384;
    it.diffuse_rgb = {3{16'h4000}};
    it.specular_rgb = {3{16'h4000}};
    it.light_rgb = {3{16'h4000}};
    // mirror geometry: v along r, head-on light
    it.normal_xyz = vec3(0, 0, one);
    it.light_dir_xyz = vec3(0, 0, one);
    it.ray_dir_xyz = vec3(0, 0, -one);
    foreach (it.shininess[b]) begin
      it.shininess = 8'(1 << b);
      send_hit(it);
    end
    // zero exponent, with cos of zero
    it.shininess = 8'd0;
    it.ray_dir_xyz = vec3(0, 0, one);
    send_hit(it);
    // negative ln, light behind surface
    it.light_dir_xyz = vec3(0, 0, -one);
    it.shininess = 8'd5;
    send_hit(it);
    // zero-length reflection: l = 0, n = 0
    it.light_dir_xyz = '0;
    it.normal_xyz = '0;
    send_hit(it);
    // non-unit vectors giving cos above one
    it.normal_xyz = vec3(0, 0, 32767);
    it.light_dir_xyz = vec3(0, 0, 32767);
    it.ray_dir_xyz = vec3(-32768, -32768, -32768);
    it.shininess = 8'd1;
    send_hit(it);
    // most negative components
    it.normal_xyz = vec3(-32768, -32768, -32768);
    it.light_dir_xyz = vec3(-32768, -32768, -32768);
    it.ray_dir_xyz = '1;
    it.shininess = 8'hFF;
    send_hit(it);
    // color overflow at the extremes
    it.diffuse_rgb = '1;
    it.specular_rgb = '1;
    it.light_rgb = '1;
    it.normal_xyz = vec3(0, 0, one);
    it.light_dir_xyz = vec3(0, 0, one);
    it.ray_dir_xyz = vec3(0, 0, -one);
    it.shininess = 8'd0;
    send_hit(it);
    it.light_rgb = '0;
    send_hit(it);
  endtask

  task automatic test_random(int count, int pct);
    gap_pct = pct;
    repeat (count) send_hit(rand_hit());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(170, 25);
    test_random(170, 75);
    test_random(170, 0);
    start <= 1'b0;
    while (color_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("sent %0d hit points (directed and random), checked %0d colors", n_sent, n_seen);
    if (n_fail == 0 && color_q.size() == 0) begin
      $display("phong_diffuse_specular_shader_core regression: pass");
    end else begin
      $display("phong_diffuse_specular_shader_core regression: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("phong_diffuse_specular_shader_core regression: fail");
    $finish;
  end

endmodule
